// ===== rtl/chct_pkg.sv =====
package chct_pkg;

    // Image store dimensions
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // Fixed field widths
    localparam int CW       = 10;   // internal coordinate and dimension width
    localparam int PW       = 12;   // signed neighbour position width
    localparam int PFW      = 13;   // predicted point width
    localparam int PRED_FB  = 4;    // fraction bits of the predicted point
    localparam int SCORE_FB = 16;   // fraction bits of scores
    localparam int SCW      = 25;   // score width
    localparam int EW       = 16;   // signed distance error width
    localparam int DSW      = 2 * EW + 1;           // sum of squares width
    localparam int DENW     = DSW + 7 + 8 + 1;      // divisor width
    localparam int NW       = DENW + 1;             // dividend width
    localparam int QW       = SCORE_FB + 10;        // quotient bits
    localparam int QCW      = $clog2(QW);
    localparam int NUMW     = 16 + SCORE_FB + 2 * PRED_FB;

    localparam logic [SCW-1:0] SCORE_MAX = {SCW{1'b1}};
    localparam int SIGMA_INV_SQ = 100;
    localparam int ONE_SQ       = 1 << (2 * PRED_FB);

    // Register indexes
    localparam logic [1:0] REG_LAMBDA = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_STEPS  = 2'd3;

    // Candidate scan order: dx outer, dy inner; centre is the fifth
    localparam logic [3:0] K_FIRST  = 4'd0;
    localparam logic [3:0] K_CENTRE = 4'd4;
    localparam logic [3:0] K_LAST   = 4'd8;

    typedef struct packed {
        logic       pix_write;
        logic       start_load;
        logic       start_cap;
        logic       cand_addr;
        logic       cand_sq;
        logic       cand_den;
        logic       div_init;
        logic       div_step;
        logic       cand_cmp;
        logic       decide;
        logic       out_load;
        logic [3:0] k;
    } chct_cmd_t;

    typedef struct packed {
        logic climb_done;
        logic out_free;
    } chct_stat_t;

endpackage

// ===== rtl/chct_ram.sv =====
module chct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/chct_ctrl.sv =====
module chct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_kind,
    output logic                s_tready,
    input  chct_pkg::chct_stat_t stat,
    output chct_pkg::chct_cmd_t  cmd
);
    import chct_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START_RD = 4'd1;
    localparam logic [3:0] S_START_CP = 4'd2;
    localparam logic [3:0] S_ADDR     = 4'd3;
    localparam logic [3:0] S_SQ       = 4'd4;
    localparam logic [3:0] S_DEN      = 4'd5;
    localparam logic [3:0] S_DINIT    = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_CMP      = 4'd8;
    localparam logic [3:0] S_DECIDE   = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0]     state_reg, state_next;
    logic [3:0]     k_reg, k_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic           accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Sequence the climb
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.k      = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.pix_write  = accept && !s_kind;
                cmd.start_load = accept && s_kind;
                if (accept && s_kind)
                begin
                    state_next = S_START_RD;
                end
            end
            S_START_RD:
            begin
                state_next = S_START_CP;
            end
            S_START_CP:
            begin
                cmd.start_cap = 1'b1;
                k_next        = K_FIRST;
                state_next    = S_ADDR;
            end
            S_ADDR:
            begin
                if (k_reg == K_CENTRE)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    cmd.cand_addr = 1'b1;
                    state_next    = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.cand_sq = 1'b1;
                state_next  = S_DEN;
            end
            S_DEN:
            begin
                cmd.cand_den = 1'b1;
                state_next   = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == QCW'(QW - 1))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cand_cmp = 1'b1;
                if (k_reg == K_LAST)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                k_next     = K_FIRST;
                state_next = stat.climb_done ? S_FIN : S_ADDR;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/chct_dp.sv =====
module chct_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  chct_pkg::chct_cmd_t  cmd,
    output chct_pkg::chct_stat_t stat,
    input  logic [55:0]          s_tdata,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata
);
    import chct_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Offsets of candidate k
    function automatic logic signed [PW-1:0] off_x(input logic [3:0] k);
        logic signed [PW-1:0] o;
        o = '0;
        unique case (k)
            4'd0, 4'd1, 4'd2: o = -PW'(1);
            4'd6, 4'd7, 4'd8: o = PW'(1);
            default:          o = '0;
        endcase
        return o;
    endfunction

    function automatic logic signed [PW-1:0] off_y(input logic [3:0] k);
        logic signed [PW-1:0] o;
        o = '0;
        unique case (k)
            4'd0, 4'd3, 4'd6: o = -PW'(1);
            4'd2, 4'd5, 4'd8: o = PW'(1);
            default:          o = '0;
        endcase
        return o;
    endfunction

    // Reflect-101 index into a dimension of n
    function automatic logic [CW-1:0] reflect(input logic signed [PW-1:0] v,
                                              input logic [CW-1:0] n);
        logic [CW-1:0] r;
        if (n <= CW'(1))
            r = '0;
        else if (v < 0)
            r = CW'(1);
        else if (v >= $signed({{(PW-CW){1'b0}}, n}))
            r = n - CW'(2);
        else
            r = v[CW-1:0];
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // Configuration registers
    logic [15:0]   lambda_reg;
    logic [CW-1:0] iw_reg, ih_reg, ms_reg;
    logic [CW-1:0] w_eff, h_eff, limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg <= 16'd1280;
            iw_reg     <= CW'(512);
            ih_reg     <= CW'(512);
            ms_reg     <= CW'(1023);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAMBDA: lambda_reg <= cfg_wdata;
                REG_WIDTH:  iw_reg     <= cfg_wdata[CW-1:0];
                REG_HEIGHT: ih_reg     <= cfg_wdata[CW-1:0];
                REG_STEPS:  ms_reg     <= cfg_wdata[CW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = (iw_reg == '0) ? CW'(1) : iw_reg;
        if (32'(w_eff) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        h_eff = (ih_reg == '0) ? CW'(1) : ih_reg;
        if (32'(h_eff) > MAX_HEIGHT)
            h_eff = CW'(MAX_HEIGHT);
        limit = (ms_reg == '0) ? CW'(1) : ms_reg;
    end

    // Input fields
    logic [8:0]     in_col, in_row;
    logic [7:0]     in_pix;
    logic [PFW-1:0] in_pc, in_pr;

    assign in_col = s_tdata[8:0];
    assign in_row = s_tdata[17:9];
    assign in_pix = s_tdata[25:18];
    assign in_pc  = s_tdata[38:26];
    assign in_pr  = s_tdata[51:39];

    // Climb state
    logic [CW-1:0]  cur_col_reg, cur_row_reg;
    logic [SCW-1:0] cur_score_reg;
    logic [CW-1:0]  step_reg;
    logic           border_reg, limited_reg;
    logic [PFW-1:0] pc_reg, pr_reg;

    // Image store
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    assign ram_we    = cmd.pix_write && (32'(in_col) < MAX_WIDTH)
                       && (32'(in_row) < MAX_HEIGHT);
    assign ram_waddr = addr_of(CW'(in_col), CW'(in_row));

    chct_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_pix),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Neighbour position, reflected address and distance error
    logic signed [PW-1:0] nb_x, nb_y;
    logic signed [EW:0]   ex_full, ey_full;

    assign nb_x = $signed({{(PW-CW){1'b0}}, cur_col_reg}) + off_x(cmd.k);
    assign nb_y = $signed({{(PW-CW){1'b0}}, cur_row_reg}) + off_y(cmd.k);
    assign ex_full = {{(EW+1-PW-PRED_FB){nb_x[PW-1]}}, nb_x, {PRED_FB{1'b0}}}
                     - {{(EW+1-PFW){1'b0}}, pc_reg};
    assign ey_full = {{(EW+1-PW-PRED_FB){nb_y[PW-1]}}, nb_y, {PRED_FB{1'b0}}}
                     - {{(EW+1-PFW){1'b0}}, pr_reg};
    assign ram_raddr = cmd.cand_addr
                       ? addr_of(reflect(nb_x, w_eff), reflect(nb_y, h_eff))
                       : addr_of(cur_col_reg, cur_row_reg);

    // Weight pipeline and divider
    logic signed [EW-1:0] ex_reg, ey_reg;
    logic [2*EW-1:0]      sqx_reg, sqy_reg;
    logic [7:0]           pix_reg;
    logic [DENW-1:0]      den_reg, rem_reg;
    logic [QW-1:0]        nlo_reg, q_reg;
    logic [DSW-1:0]       d_sum;
    logic [NW-1:0]        dividend;
    logic [DENW:0]        trial;

    assign d_sum    = DSW'(sqx_reg) + DSW'(sqy_reg);
    assign dividend = NW'({lambda_reg, {(NUMW-16){1'b0}}}) + NW'(den_reg >> 1);
    assign trial    = {rem_reg, nlo_reg[QW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.cand_addr)
        begin
            ex_reg <= ex_full[EW-1:0];
            ey_reg <= ey_full[EW-1:0];
        end
        if (cmd.cand_sq)
        begin
            pix_reg <= ram_rdata;
            sqx_reg <= $unsigned((2*EW)'(ex_reg) * (2*EW)'(ex_reg));
            sqy_reg <= $unsigned((2*EW)'(ey_reg) * (2*EW)'(ey_reg));
        end
        if (cmd.cand_den)
        begin
            den_reg <= (DENW'(d_sum) * DENW'(SIGMA_INV_SQ) + DENW'(ONE_SQ)) << 8;
        end
        if (cmd.div_init)
        begin
            rem_reg <= DENW'(dividend >> QW);
            nlo_reg <= dividend[QW-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            // Restoring step: one quotient bit
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= DENW'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DENW-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
            nlo_reg <= {nlo_reg[QW-2:0], 1'b0};
        end
    end

    // Candidate score with saturation
    logic [QW:0]    cand_sum;
    logic [SCW-1:0] cand_score;

    assign cand_sum = (QW+1)'({pix_reg, {SCORE_FB{1'b0}}}) + (QW+1)'(q_reg);
    always_comb
    begin
        if (cmd.k == K_CENTRE)
            cand_score = cur_score_reg;
        else if (cand_sum > (QW+1)'(SCORE_MAX))
            cand_score = SCORE_MAX;
        else
            cand_score = cand_sum[SCW-1:0];
    end

    // Best candidate
    logic [SCW-1:0] best_reg;
    logic [3:0]     best_k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.cand_cmp && ((cmd.k == K_FIRST) || (cand_score > best_reg)))
        begin
            best_reg   <= cand_score;
            best_k_reg <= cmd.k;
        end
    end

    // Move decision
    logic signed [PW-1:0] mv_x, mv_y;
    logic [CW-1:0]        new_col, new_row, step_inc;
    logic                 out_img, at_centre, reach_limit;

    always_comb
    begin
        mv_x    = $signed({{(PW-CW){1'b0}}, cur_col_reg}) + off_x(best_k_reg);
        mv_y    = $signed({{(PW-CW){1'b0}}, cur_row_reg}) + off_y(best_k_reg);
        out_img = 1'b0;
        new_col = mv_x[CW-1:0];
        new_row = mv_y[CW-1:0];
        if (mv_x < 0)
        begin
            new_col = '0;
            out_img = 1'b1;
        end
        else if (mv_x >= $signed({{(PW-CW){1'b0}}, w_eff}))
        begin
            new_col = w_eff - CW'(1);
            out_img = 1'b1;
        end
        if (mv_y < 0)
        begin
            new_row = '0;
            out_img = 1'b1;
        end
        else if (mv_y >= $signed({{(PW-CW){1'b0}}, h_eff}))
        begin
            new_row = h_eff - CW'(1);
            out_img = 1'b1;
        end
        step_inc    = step_reg + CW'(1);
        at_centre   = (best_k_reg == K_CENTRE);
        reach_limit = (step_inc >= limit);
    end

    assign stat.climb_done = at_centre || out_img || reach_limit;

    // Climb registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_score_reg <= '0;
            step_reg      <= '0;
            border_reg    <= 1'b0;
            limited_reg   <= 1'b0;
        end
        else if (cmd.start_load)
        begin
            // Clamp the start into the image
            border_reg  <= (CW'(in_col) >= w_eff) || (CW'(in_row) >= h_eff);
            cur_col_reg <= (CW'(in_col) >= w_eff) ? w_eff - CW'(1) : CW'(in_col);
            cur_row_reg <= (CW'(in_row) >= h_eff) ? h_eff - CW'(1) : CW'(in_row);
            limited_reg <= 1'b0;
        end
        else if (cmd.start_cap)
        begin
            cur_score_reg <= SCW'({ram_rdata, {SCORE_FB{1'b0}}});
            step_reg      <= '0;
        end
        else if (cmd.decide)
        begin
            cur_score_reg <= best_reg;
            if (!at_centre)
            begin
                cur_col_reg <= new_col;
                cur_row_reg <= new_row;
                step_reg    <= step_inc;
                border_reg  <= border_reg || out_img;
                limited_reg <= !out_img && reach_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_load)
        begin
            pc_reg <= in_pc;
            pr_reg <= in_pr;
        end
    end

    // Output register
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    assign stat.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {3'b000, border_reg, limited_reg, cur_score_reg,
                             cur_row_reg[8:0], cur_col_reg[8:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/curvature_hill_climb_tracker.sv =====
// Curvature hill-climb tracker.
// Slave stream: tuser is the item kind (0 writes a pixel, 1 tracks a point);
// tdata carries col, row, pixel_value, pred_col, pred_row. A pixel write is
// stored as it is accepted. A track item starts a climb over the stored
// image and gives one result on the master stream: final_col, final_row,
// final_score, hit_limit, hit_border.
// A climb runs neighbourhood scans, one per move, plus a last one in which
// the centre wins if the climb ends there. Each scan takes the eight
// neighbours in turn through the restoring divider that forms the distance
// weight; the image memory gives one pixel a cycle.
// Items are taken one at a time; tready is high only between climbs.
// The result waits in an output register; a stalled receiver holds it there,
// pixel writes and a new climb go on, and only the end of the next climb
// waits for the register to free.
// Reset clears the control state and loads the register defaults; the image
// memory is not cleared and must be written before it is read.
// Configuration writes take effect at once; the user must see that they are
// made while idle, as the block does not enforce it.
module curvature_hill_climb_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col[8:0], row[17:9], pixel_value[25:18], pred_col[38:26], pred_row[51:39]
    input  logic [55:0] s_tdata,
    // kind
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // final_col[8:0], final_row[17:9], final_score[42:18], hit_limit[43],
    // hit_border[44]
    output logic [47:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import chct_pkg::*;

    chct_cmd_t  cmd;
    chct_stat_t stat;

    chct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chct_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/curvature_hill_climb_tracker_tb.sv =====
`timescale 1ns / 100ps

module curvature_hill_climb_tracker_tb;

    import chct_pkg::*;

    localparam int IMG_W = 512;
    localparam int IMG_H = 512;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [8:0]     col;
        logic [8:0]     row;
        logic [SCW-1:0] score;
        logic           limit;
        logic           border;
    } climb_res_t;

    typedef struct {
        logic        kind;
        logic [8:0]  col;
        logic [8:0]  row;
        logic [7:0]  pix;
        logic [12:0] pc;
        logic [12:0] pr;
        logic        typed;
        climb_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // Copy of the image and of the registers for prediction
    logic [7:0]  img [0:IMG_W*IMG_H-1];
    bit          img_written [0:IMG_W*IMG_H-1];
    int unsigned lambda_q;
    int unsigned width_q;
    int unsigned height_q;
    int unsigned steps_q;

    climb_res_t  climb_q[$];
    int          errors;
    int          n_tracks;
    int          n_writes;
    int          n_settings;
    int          snd_idle;
    int          rcv_idle;
    logic        pressure_go;
    logic        pressure_done;
    int          hold_left;

    curvature_hill_climb_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Reflect-101 index into a dimension of n
    function automatic longint reflect101(longint v, longint n);
        if (n <= 1)
            return 0;
        if (v < 0)
            return 1;
        if (v >= n)
            return n - 2;
        return v;
    endfunction

    // Pixel plus distance weight of a neighbour, saturated
    function automatic longint weighted_score(longint x, longint y, longint pc, longint pr,
                                              longint w, longint h);
        longint pix;
        longint ex;
        longint ey;
        longint d2;
        longint den;
        longint num;
        longint term;
        longint s;
        pix  = img[reflect101(y, h) * IMG_W + reflect101(x, w)];
        ex   = x * 16 - pc;
        ey   = y * 16 - pr;
        d2   = ex * ex + ey * ey;
        den  = 256 * (100 * d2 + 256);
        num  = longint'(lambda_q) << 24;
        term = (num + den / 2) / den;
        s    = (pix << 16) + term;
        return (s > longint'(SCORE_MAX)) ? longint'(SCORE_MAX) : s;
    endfunction

    // Climb from a start pixel to the local best
    function automatic climb_res_t climb(logic [8:0] col, logic [8:0] row,
                                         logic [12:0] pc, logic [12:0] pr);
        climb_res_t r;
        longint w;
        longint h;
        longint lim;
        longint cx;
        longint cy;
        longint cs;
        longint best;
        longint bdx;
        longint bdy;
        longint s;
        longint nx;
        longint ny;
        int     steps;
        bit     border;
        bit     limited;
        bit     out_img;
        w = (width_q == 0) ? 1 : ((width_q > IMG_W) ? IMG_W : width_q);
        h = (height_q == 0) ? 1 : ((height_q > IMG_H) ? IMG_H : height_q);
        lim = (steps_q == 0) ? 1 : steps_q;
        border = 0;
        limited = 0;
        cx = col;
        cy = row;
        if (cx >= w)
        begin
            cx = w - 1;
            border = 1;
        end
        if (cy >= h)
        begin
            cy = h - 1;
            border = 1;
        end
        cs = longint'(img[cy * IMG_W + cx]) << 16;
        steps = 0;
        forever
        begin
            best = -100000;
            bdx = 0;
            bdy = 0;
            for (int dx = -1; dx <= 1; dx++)
            begin
                for (int dy = -1; dy <= 1; dy++)
                begin
                    if (dx == 0 && dy == 0)
                        s = cs;
                    else
                        s = weighted_score(cx + dx, cy + dy, pc, pr, w, h);
                    if (s > best)
                    begin
                        best = s;
                        bdx = dx;
                        bdy = dy;
                    end
                end
            end
            cs = best;
            if (bdx == 0 && bdy == 0)
                break;
            nx = cx + bdx;
            ny = cy + bdy;
            out_img = 0;
            if (nx < 0)
            begin
                nx = 0;
                out_img = 1;
            end
            if (nx >= w)
            begin
                nx = w - 1;
                out_img = 1;
            end
            if (ny < 0)
            begin
                ny = 0;
                out_img = 1;
            end
            if (ny >= h)
            begin
                ny = h - 1;
                out_img = 1;
            end
            cx = nx;
            cy = ny;
            steps++;
            if (out_img)
            begin
                border = 1;
                break;
            end
            if (steps >= lim)
            begin
                limited = 1;
                break;
            end
        end
        r.col    = cx[8:0];
        r.row    = cy[8:0];
        r.score  = cs[SCW-1:0];
        r.limit  = limited;
        r.border = border;
        return r;
    endfunction

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_item(stim_row_t it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {4'd0, it.pr, it.pc, it.pix, it.row, it.col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.kind)
        begin
            climb_q.insert(climb_q.size(),
                           it.typed ? it.res : climb(it.col, it.row, it.pc, it.pr));
            n_tracks++;
        end
        else
        begin
            img[it.row * IMG_W + it.col] = it.pix;
            img_written[it.row * IMG_W + it.col] = 1;
            n_writes++;
        end
        if ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle);
        end
    endtask

    // Stop offering, wait for every result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (climb_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    // Write all four registers; only called while idle
    task automatic write_setting(int unsigned lam, int unsigned w, int unsigned h,
                                 int unsigned st);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LAMBDA;
        cfg_wdata <= lam[15:0];
        @(posedge clk);
        cfg_index <= REG_WIDTH;
        cfg_wdata <= w[15:0];
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_wdata <= h[15:0];
        @(posedge clk);
        cfg_index <= REG_STEPS;
        cfg_wdata <= st[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        lambda_q = lam & 16'hFFFF;
        width_q  = w & 10'h3FF;
        height_q = h & 10'h3FF;
        steps_q  = st & 10'h3FF;
        n_settings++;
        @(posedge clk);
    endtask

    function automatic stim_row_t mk(logic kind, int c, int r, int p, int pc, int pr);
        stim_row_t it;
        it.kind  = kind;
        it.col   = c[8:0];
        it.row   = r[8:0];
        it.pix   = p[7:0];
        it.pc    = pc[12:0];
        it.pr    = pr[12:0];
        it.typed = 0;
        it.res   = '0;
        return it;
    endfunction

    function automatic stim_row_t mk_typed(int c, int r, int pc, int pr, int ec, int er,
                                           int escore, bit elim, bit ebord);
        stim_row_t it;
        it = mk(1'b1, c, r, 0, pc, pr);
        it.typed = 1;
        it.res.col = ec[8:0];
        it.res.row = er[8:0];
        it.res.score = escore[SCW-1:0];
        it.res.limit = elim;
        it.res.border = ebord;
        return it;
    endfunction

    // Random item, mostly within the current image
    function automatic stim_row_t rand_item();
        stim_row_t it;
        int w;
        int h;
        int c;
        int r;
        int pc;
        int pr;
        w = width_q;
        h = height_q;
        if ($urandom_range(99) < 55)
        begin
            c = ($urandom_range(99) < 20) ? $urandom_range(511) : $urandom_range(w);
            r = ($urandom_range(99) < 20) ? $urandom_range(511) : $urandom_range(h);
            if (c > 511)
                c = 511;
            if (r > 511)
                r = 511;
            if ($urandom_range(99) < 10)
            begin
                pc = $urandom_range(8191);
                pr = $urandom_range(8191);
            end
            else
            begin
                pc = $urandom_range(w - 1) * 16 + $urandom_range(63) - 24;
                pr = $urandom_range(h - 1) * 16 + $urandom_range(63) - 24;
                pc = (pc < 0) ? 0 : ((pc > 8191) ? 8191 : pc);
                pr = (pr < 0) ? 0 : ((pr > 8191) ? 8191 : pr);
            end
            it = mk(1'b1, c, r, $urandom_range(255), pc, pr);
        end
        else if ($urandom_range(99) < 85)
            it = mk(1'b0, $urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255),
                    $urandom_range(8191), $urandom_range(8191));
        else
            it = mk(1'b0, $urandom_range(511), $urandom_range(511), $urandom_range(255),
                    $urandom_range(8191), $urandom_range(8191));
        return it;
    endfunction

    // Write every pixel of the image region not yet written
    task automatic fill_region();
        for (int r = 0; r < height_q; r++)
            for (int c = 0; c < width_q; c++)
                if (!img_written[r * IMG_W + c])
                    send_item(mk(1'b0, c, r, $urandom_range(255), $urandom_range(8191),
                                 $urandom_range(8191)));
    endtask

    // Receiver: check each result, stall at random or for the long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready      <= 1'b0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                climb_res_t got;
                climb_res_t want;
                got.col    = m_tdata[8:0];
                got.row    = m_tdata[17:9];
                got.score  = m_tdata[42:18];
                got.limit  = m_tdata[43];
                got.border = m_tdata[44];
                if (climb_q.size() == 0)
                begin
                    $error("result with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = climb_q.pop_front();
                    if (got.col !== want.col)
                    begin
                        $error("final_col expected %0d got %0d", want.col, got.col);
                        errors++;
                    end
                    if (got.row !== want.row)
                    begin
                        $error("final_row expected %0d got %0d", want.row, got.row);
                        errors++;
                    end
                    if (got.score !== want.score)
                    begin
                        $error("final_score expected %0d got %0d", want.score, got.score);
                        errors++;
                    end
                    if (got.limit !== want.limit)
                    begin
                        $error("hit_limit expected %0d got %0d", want.limit, got.limit);
                        errors++;
                    end
                    if (got.border !== want.border)
                    begin
                        $error("hit_border expected %0d got %0d", want.border, got.border);
                        errors++;
                    end
                end
            end
            if (pressure_go && !pressure_done)
            begin
                hold_left     <= HOLD_CYCLES;
                pressure_done <= 1'b1;
                m_tready      <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Overall time limit
    initial
    begin
        #1s;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t dir_a [$];
        stim_row_t dir_b [$];
        stim_row_t dir_c [$];
        int lam;
        int w;
        int h;
        int st;

        errors = 0;
        n_tracks = 0;
        n_writes = 0;
        n_settings = 0;
        snd_idle = 37;
        rcv_idle = 48;
        pressure_go = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LAMBDA;
        cfg_wdata = '0;
        for (int i = 0; i < IMG_W * IMG_H; i++)
        begin
            img[i] = 8'd0;
            img_written[i] = 0;
        end
        lambda_q = 1280;
        width_q  = 512;
        height_q = 512;
        steps_q  = 1023;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-pixel image, no distance weight: the first neighbour ties the
        // centre, wins, and leaves the image at once
        dir_a = {dir_a, mk(1'b0, 0, 0, 255, 0, 0)};
        dir_a = {dir_a, mk_typed(0, 0, 0, 0, 0, 0, 255 << 16, 0, 1)};
        dir_a = {dir_a, mk_typed(511, 511, 8191, 8191, 0, 0, 255 << 16, 0, 1)};
        dir_a = {dir_a, mk(1'b0, 511, 511, 170, 8191, 8191)};
        dir_a = {dir_a, mk(1'b0, 0, 0, 0, 0, 0)};
        dir_a = {dir_a, mk_typed(0, 0, 8191, 0, 0, 0, 0, 0, 1)};
        write_setting(0, 1, 1, 1023);
        foreach (dir_a[i])
            send_item(dir_a[i]);
        drain();

        // 2x2 image, full weight, single step
        dir_b = {dir_b, mk(1'b0, 0, 0, 0, 0, 0)};
        dir_b = {dir_b, mk(1'b0, 1, 0, 128, 0, 0)};
        dir_b = {dir_b, mk(1'b0, 0, 1, 255, 0, 0)};
        dir_b = {dir_b, mk(1'b0, 1, 1, 7, 0, 0)};
        dir_b = {dir_b, mk(1'b1, 0, 0, 0, 0, 0)};
        dir_b = {dir_b, mk(1'b1, 1, 1, 0, 8191, 8191)};
        dir_b = {dir_b, mk(1'b1, 1, 0, 0, 16, 16)};
        dir_b = {dir_b, mk(1'b1, 300, 0, 0, 0, 16)};
        write_setting(65535, 2, 2, 1);
        foreach (dir_b[i])
            send_item(dir_b[i]);
        drain();

        // 3x3 flat image: the weight alone pulls the climb to the prediction
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                dir_c = {dir_c, mk(1'b0, c, r, 9, 0, 0)};
        dir_c = {dir_c, mk(1'b1, 0, 0, 0, 32, 32)};
        dir_c = {dir_c, mk(1'b1, 2, 2, 0, 8, 24)};
        write_setting(1280, 3, 3, 1023);
        foreach (dir_c[i])
            send_item(dir_c[i]);
        drain();

        // Random part: three rounds, the last without random idling, over a spread of settings
        for (int round = 0; round < 3; round++)
        begin
            snd_idle = (round == 0) ? 37 : ((round == 1) ? 48 : 0);
            rcv_idle = (round == 0) ? 48 : ((round == 1) ? 37 : 0);
            for (int ph = 0; ph < 6; ph++)
            begin
                lam = $urandom_range(65535);
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
                st = ($urandom_range(1) != 0) ? $urandom_range(1, 4) : $urandom_range(1, 1023);
                if (round == 0 && ph == 0)
                begin
                    lam = 0;
                    w = 512;
                    h = 1;
                    st = 1023;
                end
                if (round == 0 && ph == 1)
                begin
                    lam = 65535;
                    w = 1;
                    h = 512;
                    st = 1;
                end
                drain();
                write_setting(lam, w, h, st);
                fill_region();
                if (round == 2 && ph == 0)
                    pressure_go <= 1'b1;
                for (int n = 0; n < 22; n++)
                    send_item(rand_item());
            end
        end

        drain();
        repeat (300)
            @(posedge clk);
        if (climb_q.size() != 0)
        begin
            $error("%0d results never arrived", climb_q.size());
            errors++;
        end
        $display("Covered %0d climbs and %0d pixel writes over %0d register settings,",
                 n_tracks, n_writes, n_settings);
        $display("with random stalls on both sides and one long output hold.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
